[rtl/core/pbs_pkg.sv]
// shared types for the patch bounding sphere pipeline
package pbs_pkg;

  // outcome of merging the two pair spheres
  typedef enum logic [1:0] {
    MODE_KEEP_A,
    MODE_KEEP_B,
    MODE_BLEND
  } mode_e;

endpackage

[rtl/core/patch_bounding_sphere.sv]
// top level: pipelined bounding sphere of a four-corner patch
// throughput: one item per cycle unless a result waits at the output; both square
// roots and the three dividers are fully pipelined, one root or quotient bit per stage
// stalls freeze the whole pipeline while the output register holds an untaken result
// reset (rst_ni low, asynchronous) clears all valid bits; data registers are not reset
module patch_bounding_sphere #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [COORD_WIDTH-1:0] corner0_x_i,
  input  logic [COORD_WIDTH-1:0] corner0_y_i,
  input  logic [COORD_WIDTH-1:0] corner0_z_i,
  input  logic [COORD_WIDTH-1:0] corner1_x_i,
  input  logic [COORD_WIDTH-1:0] corner1_y_i,
  input  logic [COORD_WIDTH-1:0] corner1_z_i,
  input  logic [COORD_WIDTH-1:0] corner2_x_i,
  input  logic [COORD_WIDTH-1:0] corner2_y_i,
  input  logic [COORD_WIDTH-1:0] corner2_z_i,
  input  logic [COORD_WIDTH-1:0] corner3_x_i,
  input  logic [COORD_WIDTH-1:0] corner3_y_i,
  input  logic [COORD_WIDTH-1:0] corner3_z_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [COORD_WIDTH-1:0] center_x_o,
  output logic [COORD_WIDTH-1:0] center_y_o,
  output logic [COORD_WIDTH-1:0] center_z_o,
  output logic [COORD_WIDTH-2:0] radius_o
);
  import pbs_pkg::*;

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned DW  = W + 1;          // coordinate difference
  localparam int unsigned SQW = 2 * DW;         // one square
  localparam int unsigned SW  = 2 * DW + 2;     // sum of three squares
  localparam int unsigned TW  = SW + 1;         // root trial value
  localparam int unsigned RW  = DW + 1;         // root
  localparam int unsigned PW  = W + DW;         // radius difference times axis distance
  localparam int unsigned QW  = W;              // quotient

  localparam int unsigned S_IN   = 0;
  localparam int unsigned S_SQA  = S_IN + 1;
  localparam int unsigned S_SUMA = S_SQA + 1;
  localparam int unsigned S_RTA  = S_SUMA + RW;
  localparam int unsigned S_PAIR = S_RTA + 1;
  localparam int unsigned S_SQB  = S_PAIR + 1;
  localparam int unsigned S_SUMB = S_SQB + 1;
  localparam int unsigned S_RTB  = S_SUMB + RW;
  localparam int unsigned S_CMP  = S_RTB + 1;
  localparam int unsigned S_MUL  = S_CMP + 1;
  localparam int unsigned S_DIV  = S_MUL + QW;
  localparam int unsigned S_OUT  = S_DIV + 1;
  localparam int unsigned NST    = S_OUT + 1;

  localparam logic [W:0] RadMax = {2'b00, {(W-1){1'b1}}};

  typedef logic [3:0][2:0][W-1:0] pts_t;

  typedef struct packed {
    logic [2:0][W-1:0] c;
    logic [W-1:0]      r;
  } ball_t;

  typedef struct packed {
    ball_t [1:0]        b;
    logic  [2:0]        zn;
    logic  [2:0][DW-1:0] zm;
  } bpay_t;

  typedef struct packed {
    ball_t [1:0]        b;
    logic  [2:0]        zn;
    logic  [2:0][DW-1:0] zm;
    logic  [RW-1:0]     n;
    logic  [W-1:0]      dr;
    logic               drn;
    mode_e              mode;
    logic  [W-2:0]      rad;
  } cpay_t;

  typedef struct packed {
    ball_t [1:0]    b;
    logic  [2:0]    neg;
    logic  [RW-1:0] n;
    mode_e          mode;
    logic  [W-2:0]  rad;
  } dpay_t;

  // global advance: the whole pipe moves unless a result waits
  logic           en;
  logic [NST-1:0] v_q;

  assign en          = !v_q[NST-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], in_valid_i};
    end
  end

  // input register
  pts_t in_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= {corner3_z_i, corner3_y_i, corner3_x_i,
               corner2_z_i, corner2_y_i, corner2_x_i,
               corner1_z_i, corner1_y_i, corner1_x_i,
               corner0_z_i, corner0_y_i, corner0_x_i};
    end
  end

  // pair distances: squared axis differences, lane 0 is corners 0-2, lane 1 is 1-3
  logic [1:0][2:0][SQW-1:0] sqa_d, sqa_q;
  pts_t                     sqa_p_q;
  always_comb begin
    logic [DW-1:0] d, m;
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < 3; k++) begin
        d = {in_q[l][k][W-1], in_q[l][k]} - {in_q[l+2][k][W-1], in_q[l+2][k]};
        m = d[DW-1] ? (~d + DW'(1)) : d;
        sqa_d[l][k] = SQW'(m) * SQW'(m);
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sqa_q   <= sqa_d;
      sqa_p_q <= in_q;
    end
  end

  // square root A, one root bit per stage
  logic [SW-1:0] ar_q [RW+1][2];
  logic [RW-1:0] ao_q [RW+1][2];
  pts_t          ap_q [RW+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        ar_q[0][l] <= SW'(sqa_q[l][0]) + SW'(sqa_q[l][1]) + SW'(sqa_q[l][2]);
        ao_q[0][l] <= '0;
      end
      ap_q[0] <= sqa_p_q;
    end
  end

  for (genvar j = 0; j < RW; j++) begin : g_rta
    localparam int unsigned B = RW - 1 - j;
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [TW-1:0] trial;
      logic          take;
      assign trial = (TW'(ao_q[j][l]) << (B + 1)) + (TW'(1) << (2 * B));
      assign take  = trial <= TW'(ar_q[j][l]);
      always_ff @(posedge clk_i) begin
        if (en) begin
          ar_q[j+1][l] <= take ? SW'(TW'(ar_q[j][l]) - trial) : ar_q[j][l];
          ao_q[j+1][l] <= take ? (ao_q[j][l] | (RW'(1) << B)) : ao_q[j][l];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        ap_q[j+1] <= ap_q[j];
      end
    end
  end

  // pair spheres: midpoint and half distance
  ball_t [1:0] pr_d, pr_q;
  always_comb begin
    logic [DW-1:0] s;
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < 3; k++) begin
        s = {ap_q[RW][l][k][W-1], ap_q[RW][l][k]}
          + {ap_q[RW][l+2][k][W-1], ap_q[RW][l+2][k]};
        pr_d[l].c[k] = (ao_q[RW][l] == '0) ? ap_q[RW][l][k] : s[DW-1:1];
      end
      pr_d[l].r = W'(ao_q[RW][l] >> 1);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_q <= pr_d;
    end
  end

  // merge distance: squared differences of the two centres
  logic [2:0][SQW-1:0] sqb_d, sqb_q;
  bpay_t               sqb_p_d, sqb_p_q;
  always_comb begin
    logic [DW-1:0] d, m;
    sqb_p_d.b = pr_q;
    for (int k = 0; k < 3; k++) begin
      d = {pr_q[0].c[k][W-1], pr_q[0].c[k]} - {pr_q[1].c[k][W-1], pr_q[1].c[k]};
      m = d[DW-1] ? (~d + DW'(1)) : d;
      sqb_p_d.zn[k] = d[DW-1];
      sqb_p_d.zm[k] = m;
      sqb_d[k]      = SQW'(m) * SQW'(m);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sqb_q   <= sqb_d;
      sqb_p_q <= sqb_p_d;
    end
  end

  // square root B
  logic [SW-1:0] br_q [RW+1];
  logic [RW-1:0] bo_q [RW+1];
  bpay_t         bp_q [RW+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      br_q[0] <= SW'(sqb_q[0]) + SW'(sqb_q[1]) + SW'(sqb_q[2]);
      bo_q[0] <= '0;
      bp_q[0] <= sqb_p_q;
    end
  end

  for (genvar j = 0; j < RW; j++) begin : g_rtb
    localparam int unsigned B = RW - 1 - j;
    logic [TW-1:0] trial;
    logic          take;
    assign trial = (TW'(bo_q[j]) << (B + 1)) + (TW'(1) << (2 * B));
    assign take  = trial <= TW'(br_q[j]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        br_q[j+1] <= take ? SW'(TW'(br_q[j]) - trial) : br_q[j];
        bo_q[j+1] <= take ? (bo_q[j] | (RW'(1) << B)) : bo_q[j];
        bp_q[j+1] <= bp_q[j];
      end
    end
  end

  // containment test, radius difference and merged radius
  cpay_t cmp_d, cmp_q;
  always_comb begin
    logic [RW:0]   na, nb;
    logic [RW+1:0] rs;
    logic [W-1:0]  r0, r1;
    r0 = bp_q[RW].b[0].r;
    r1 = bp_q[RW].b[1].r;
    na = (RW+1)'(bo_q[RW]) + (RW+1)'(r1);
    nb = (RW+1)'(bo_q[RW]) + (RW+1)'(r0);
    rs = (RW+2)'(r0) + (RW+2)'(r1) + (RW+2)'(bo_q[RW]);
    cmp_d.b   = bp_q[RW].b;
    cmp_d.zn  = bp_q[RW].zn;
    cmp_d.zm  = bp_q[RW].zm;
    cmp_d.n   = bo_q[RW];
    cmp_d.drn = r0 < r1;
    cmp_d.dr  = (r0 < r1) ? (r1 - r0) : (r0 - r1);
    if (na <= (RW+1)'(r0)) begin
      cmp_d.mode = MODE_KEEP_A;
    end else if (nb <= (RW+1)'(r1)) begin
      cmp_d.mode = MODE_KEEP_B;
    end else begin
      cmp_d.mode = MODE_BLEND;
    end
    cmp_d.rad = ((rs >> 1) > (RW+2)'(RadMax)) ? RadMax[W-2:0] : rs[W-1:1];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      cmp_q <= cmp_d;
    end
  end

  // centre shift numerators
  logic [2:0][PW-1:0] mul_d;
  dpay_t              mul_p_d;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mul_d[k]       = PW'(cmp_q.dr) * PW'(cmp_q.zm[k]);
      mul_p_d.neg[k] = cmp_q.drn ^ cmp_q.zn[k];
    end
    mul_p_d.b    = cmp_q.b;
    mul_p_d.n    = cmp_q.n;
    mul_p_d.mode = cmp_q.mode;
    mul_p_d.rad  = cmp_q.rad;
  end

  // long division by the merge distance, one quotient bit per stage
  logic [RW-1:0] dr_q [QW+1][3];
  logic [QW-1:0] dl_q [QW+1][3];
  logic [QW-1:0] dq_q [QW+1][3];
  dpay_t         dp_q [QW+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dr_q[0][k] <= RW'(mul_d[k][PW-1:QW]);
        dl_q[0][k] <= mul_d[k][QW-1:0];
        dq_q[0][k] <= '0;
      end
      dp_q[0] <= mul_p_d;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int unsigned B = QW - 1 - j;
    for (genvar k = 0; k < 3; k++) begin : g_axis
      logic [RW:0] t;
      logic        take;
      assign t    = {dr_q[j][k], dl_q[j][k][B]};
      assign take = t >= (RW+1)'(dp_q[j].n);
      always_ff @(posedge clk_i) begin
        if (en) begin
          dr_q[j+1][k] <= take ? RW'(t - (RW+1)'(dp_q[j].n)) : RW'(t);
          dl_q[j+1][k] <= dl_q[j][k];
          dq_q[j+1][k] <= take ? (dq_q[j][k] | (QW'(1) << B)) : dq_q[j][k];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dp_q[j+1] <= dp_q[j];
      end
    end
  end

  // final centre and output register
  logic [2:0][W-1:0] cen_d, cen_q;
  logic [W-2:0]      rad_d, rad_q;
  always_comb begin
    logic [W+1:0] qs, s;
    dpay_t        p;
    p = dp_q[QW];
    for (int k = 0; k < 3; k++) begin
      qs = p.neg[k] ? -(W+2)'(dq_q[QW][k]) : (W+2)'(dq_q[QW][k]);
      s  = {{2{p.b[0].c[k][W-1]}}, p.b[0].c[k]}
         + {{2{p.b[1].c[k][W-1]}}, p.b[1].c[k]} + qs;
      unique case (p.mode)
        MODE_KEEP_A: cen_d[k] = p.b[0].c[k];
        MODE_KEEP_B: cen_d[k] = p.b[1].c[k];
        default:     cen_d[k] = s[W:1];
      endcase
    end
    unique case (p.mode)
      MODE_KEEP_A: rad_d = p.b[0].r[W-2:0];
      MODE_KEEP_B: rad_d = p.b[1].r[W-2:0];
      default:     rad_d = p.rad;
    endcase
    // a kept radius can exceed the field only in its top bit
    if (p.mode == MODE_KEEP_A && p.b[0].r[W-1]) begin
      rad_d = RadMax[W-2:0];
    end
    if (p.mode == MODE_KEEP_B && p.b[1].r[W-1]) begin
      rad_d = RadMax[W-2:0];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      cen_q <= cen_d;
      rad_q <= rad_d;
    end
  end

  assign center_x_o = cen_q[0];
  assign center_y_o = cen_q[1];
  assign center_z_o = cen_q[2];
  assign radius_o   = rad_q;

endmodule

[rtl/core/patch_bounding_sphere_chk.sv]
// port-level checker for the patch bounding sphere, bound to the top level
module patch_bounding_sphere_chk #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [COORD_WIDTH-1:0] center_x_o,
  input logic [COORD_WIDTH-2:0] radius_o
);

  // an empty output register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with no result pending");

  // a waiting result freezes the pipe, so no item may enter
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("item accepted while pipeline stalled");

  // a result waiting for the sink keeps its value
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(center_x_o) && $stable(radius_o))
    else $error("stalled item changed");

endmodule

bind patch_bounding_sphere patch_bounding_sphere_chk #(
  .COORD_WIDTH(COORD_WIDTH)
) u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .center_x_o  (center_x_o),
  .radius_o    (radius_o)
);
